// ===== src/obr_pkg.sv =====
// Shared types and constants for the overwriting byte ring.
// Used by overwriting_byte_ring_with_line_extract; depends on nothing.
package obr_pkg;

  // Default ring depth and fixed field widths
  localparam int DEPTH_DEFAULT = 64;
  localparam int SIZE_W        = 7;
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 7;
  localparam int FILL_W        = 6;

  // Line ending characters
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

  // Operation codes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_LINE  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_CR_RD,
    ST_CR_CHK,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

// ===== src/overwriting_byte_ring_with_line_extract.sv =====
// Overwriting byte ring with line extraction: ring memory, sequencer, result register.
// Depends on obr_pkg (types, op codes, line ending constants).
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+----------------------------
//  command   | op, data_in, line_limit                        | taken when start & !busy & !size_we
//  result    | status, out_byte, line_length, last_of_run,    | result_valid, one cycle
//            | fill_count, dropped_oldest                     |
//  size reg  | size_data                                      | written when size_we & !busy
//
// Put, clear and a get on an empty ring form their result in idle; it shows the next cycle.
// Get passes through a registered ring memory read, then the result (state ST_GET).
// Get line reads and checks each scanned byte in turn; a CR with a held byte after it adds a
// read and check of that byte, a scan that finds no line ends in a read state that reports it,
// then each line byte is read and emitted; the single ring read port is shared by both.
// Reset (rst, synchronous) empties the ring and sets size to DEPTH; memory is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module overwriting_byte_ring_with_line_extract #(
  parameter int DEPTH = obr_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [obr_pkg::BYTE_W-1:0]  data_in,
  input  logic [obr_pkg::LEN_W-1:0]   line_limit,
  input  logic                        size_we,
  input  logic [obr_pkg::SIZE_W-1:0]  size_data,
  output logic                        result_valid,
  output logic                        status,
  output logic [obr_pkg::BYTE_W-1:0]  out_byte,
  output logic [obr_pkg::LEN_W-1:0]   line_length,
  output logic                        last_of_run,
  output logic [obr_pkg::FILL_W-1:0]  fill_count,
  output logic                        dropped_oldest
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Control registers
  obr_pkg::state_t    state, state_next;
  logic [IDX_W-1:0]   w_idx, w_idx_next;
  logic [IDX_W-1:0]   r_idx, r_idx_next;
  logic [IDX_W-1:0]   fill, fill_next;
  logic [CNT_W-1:0]   size, size_next;
  logic [IDX_W-1:0]   scan_idx, scan_idx_next;
  logic [IDX_W-1:0]   pos, pos_next;
  logic [IDX_W-1:0]   cnt, cnt_next;
  logic [obr_pkg::LEN_W-1:0] scan_lim, scan_lim_next;
  logic               result_valid_next;

  // Result payload next values
  logic                        status_next;
  logic [obr_pkg::BYTE_W-1:0]  out_byte_next;
  logic [obr_pkg::LEN_W-1:0]   line_length_next;
  logic                        last_of_run_next;
  logic [obr_pkg::FILL_W-1:0]  fill_count_next;
  logic                        dropped_oldest_next;

  // Ring memory
  logic [obr_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [obr_pkg::BYTE_W-1:0] rd_data;
  logic [IDX_W-1:0]           rd_addr;
  logic                       mem_we;

  logic accept;
  logic full;
  logic [CNT_W-1:0] fill_calc;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i,
                                           input logic [CNT_W-1:0] sz);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(i) + CNT_W'(1);
    return (nx >= sz) ? '0 : nx[IDX_W-1:0];
  endfunction

  assign busy   = (state != obr_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (CNT_W'(fill) + CNT_W'(1)) == size;
  assign mem_we = accept && (op == obr_pkg::OP_PUT) && !size_we;

  // Address the read port: scan pointer while scanning, else oldest byte
  assign rd_addr = (state == obr_pkg::ST_SCAN_RD || state == obr_pkg::ST_CR_RD) ?
                   scan_idx : r_idx;

  // Fill recomputed from the indices, for checking only
  assign fill_calc = (w_idx >= r_idx) ? (CNT_W'(w_idx) - CNT_W'(r_idx)) :
                     (CNT_W'(w_idx) + size - CNT_W'(r_idx));

  // Write and read the ring memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[w_idx] <= data_in;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequence operations and form results
  always_comb begin
    state_next          = state;
    w_idx_next          = w_idx;
    r_idx_next          = r_idx;
    fill_next           = fill;
    size_next           = size;
    scan_idx_next       = scan_idx;
    pos_next            = pos;
    cnt_next            = cnt;
    scan_lim_next       = scan_lim;
    result_valid_next   = 1'b0;
    status_next         = 1'b0;
    out_byte_next       = '0;
    line_length_next    = '0;
    last_of_run_next    = 1'b1;
    fill_count_next     = obr_pkg::FILL_W'(fill);
    dropped_oldest_next = 1'b0;

    case (state)
      obr_pkg::ST_IDLE: begin
        if (size_we) begin
          // Clamp the size and empty the ring
          if (size_data < obr_pkg::SIZE_W'(2)) begin
            size_next = CNT_W'(2);
          end else if (size_data > obr_pkg::SIZE_W'(DEPTH)) begin
            size_next = CNT_W'(DEPTH);
          end else begin
            size_next = size_data[CNT_W-1:0];
          end
          w_idx_next = '0;
          r_idx_next = '0;
          fill_next  = '0;
        end else if (accept) begin
          case (op)
            obr_pkg::OP_PUT: begin
              w_idx_next        = adv(w_idx, size);
              result_valid_next = 1'b1;
              if (full) begin
                // Drop the oldest byte
                r_idx_next          = adv(r_idx, size);
                dropped_oldest_next = 1'b1;
              end else begin
                fill_next       = fill + IDX_W'(1);
                fill_count_next = obr_pkg::FILL_W'(fill_next);
              end
            end
            obr_pkg::OP_GET: begin
              if (fill == '0) begin
                result_valid_next = 1'b1;
                status_next       = 1'b1;
              end else begin
                state_next = obr_pkg::ST_GET;
              end
            end
            obr_pkg::OP_LINE: begin
              scan_idx_next = r_idx;
              pos_next      = '0;
              scan_lim_next = (line_limit == '0) ? '0 :
                              line_limit - obr_pkg::LEN_W'(1);
              state_next    = obr_pkg::ST_SCAN_RD;
            end
            default: begin
              w_idx_next        = '0;
              r_idx_next        = '0;
              fill_next         = '0;
              fill_count_next   = '0;
              result_valid_next = 1'b1;
            end
          endcase
        end
      end

      obr_pkg::ST_GET: begin
        // Pop the byte read at the oldest slot
        r_idx_next        = adv(r_idx, size);
        fill_next         = fill - IDX_W'(1);
        fill_count_next   = obr_pkg::FILL_W'(fill_next);
        out_byte_next     = rd_data;
        result_valid_next = 1'b1;
        state_next        = obr_pkg::ST_IDLE;
      end

      obr_pkg::ST_SCAN_RD: begin
        if (pos == fill || obr_pkg::LEN_W'(pos) >= scan_lim) begin
          // No complete line within reach
          status_next       = 1'b1;
          result_valid_next = 1'b1;
          state_next        = obr_pkg::ST_IDLE;
        end else begin
          state_next = obr_pkg::ST_SCAN_CHK;
        end
      end

      obr_pkg::ST_SCAN_CHK: begin
        scan_idx_next = adv(scan_idx, size);
        pos_next      = pos + IDX_W'(1);
        if (rd_data == obr_pkg::CH_LF) begin
          fill_next  = fill - pos_next;
          cnt_next   = '0;
          state_next = obr_pkg::ST_EMIT_RD;
        end else if (rd_data == obr_pkg::CH_CR) begin
          if (pos_next != fill) begin
            state_next = obr_pkg::ST_CR_RD;
          end else begin
            fill_next  = fill - pos_next;
            cnt_next   = '0;
            state_next = obr_pkg::ST_EMIT_RD;
          end
        end else begin
          state_next = obr_pkg::ST_SCAN_RD;
        end
      end

      obr_pkg::ST_CR_RD: begin
        state_next = obr_pkg::ST_CR_CHK;
      end

      obr_pkg::ST_CR_CHK: begin
        // Take a following LF into the same ending
        if (rd_data == obr_pkg::CH_LF) begin
          pos_next = pos + IDX_W'(1);
        end
        fill_next  = fill - pos_next;
        cnt_next   = '0;
        state_next = obr_pkg::ST_EMIT_RD;
      end

      obr_pkg::ST_EMIT_RD: begin
        state_next = obr_pkg::ST_EMIT_OUT;
      end

      obr_pkg::ST_EMIT_OUT: begin
        // Emit one line byte and consume it
        r_idx_next        = adv(r_idx, size);
        cnt_next          = cnt + IDX_W'(1);
        out_byte_next     = rd_data;
        line_length_next  = obr_pkg::LEN_W'(pos);
        last_of_run_next  = (cnt_next == pos);
        result_valid_next = 1'b1;
        state_next        = last_of_run_next ? obr_pkg::ST_IDLE : obr_pkg::ST_EMIT_RD;
      end

      default: begin
        state_next = obr_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= obr_pkg::ST_IDLE;
      w_idx        <= '0;
      r_idx        <= '0;
      fill         <= '0;
      size         <= CNT_W'(DEPTH);
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      w_idx        <= w_idx_next;
      r_idx        <= r_idx_next;
      fill         <= fill_next;
      size         <= size_next;
      result_valid <= result_valid_next;
    end
  end

  // Hold scan counters and result payload
  always_ff @(posedge clk) begin
    scan_idx       <= scan_idx_next;
    pos            <= pos_next;
    cnt            <= cnt_next;
    scan_lim       <= scan_lim_next;
    status         <= status_next;
    out_byte       <= out_byte_next;
    line_length    <= line_length_next;
    last_of_run    <= last_of_run_next;
    fill_count     <= fill_count_next;
    dropped_oldest <= dropped_oldest_next;
  end

  // Fill stays below the ring size
  a_fill_below_size: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(fill) < size)
    else $error("fill count reached ring size");

  // Between transactions the fill count matches the ring indices
  a_fill_matches_idx: assert property (@(posedge clk) disable iff (rst)
    (state == obr_pkg::ST_IDLE) |-> (CNT_W'(fill) == fill_calc))
    else $error("fill count disagrees with ring indices");

  // A result that is not the last of its run is followed by more work
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_of_run) |-> busy)
    else $error("line emission stopped before its last byte");

  // An empty or no-line result carries no byte and no length
  a_status_payload: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (out_byte == '0 && line_length == '0))
    else $error("failure result carries payload");

endmodule
